FILE: hdl/apr_pkg.sv
package apr_pkg;

   // classified draw; LVL_NONE only marks "no tick seen yet"
   typedef enum logic [1:0] {
      LVL_OFF     = 2'd0,
      LVL_STANDBY = 2'd1,
      LVL_ON      = 2'd2,
      LVL_NONE    = 2'd3
   } level_type;

   // pending request; REQ_UNSET only marks "no tick seen yet"
   typedef enum logic [1:0] {
      REQ_NONE  = 2'd0,
      REQ_ON    = 2'd1,
      REQ_OFF   = 2'd2,
      REQ_UNSET = 2'd3
   } req_type;

   typedef enum logic [1:0] {
      IR_NONE   = 2'd0,
      IR_WAKE   = 2'd1,
      IR_TOGGLE = 2'd2
   } ir_type;

   typedef enum logic [1:0] {
      SOCK_NONE = 2'd0,
      SOCK_ON   = 2'd1,
      SOCK_OFF  = 2'd2
   } sock_type;

   localparam int DRAW_W  = 16;
   localparam int TICKS_W = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_ON_LEVEL     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AMP_ON_LEVEL         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_OFF_WAIT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_STANDBY_WAIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_AMP_STANDBY_WAIT     = 3'd4;

   localparam logic [DRAW_W-1:0]  RST_DISPLAY_ON_LEVEL     = 16'd50;
   localparam logic [DRAW_W-1:0]  RST_AMP_ON_LEVEL         = 16'd100;
   localparam logic [TICKS_W-1:0] RST_DISPLAY_OFF_WAIT     = 8'd30;
   localparam logic [TICKS_W-1:0] RST_DISPLAY_STANDBY_WAIT = 8'd30;
   localparam logic [TICKS_W-1:0] RST_AMP_STANDBY_WAIT     = 8'd5;

   localparam logic [TICKS_W-1:0] TICKS_MAX = 8'hFF;

   typedef struct packed {
      logic [DRAW_W-1:0]  on_level;
      logic [TICKS_W-1:0] off_wait;
      logic [TICKS_W-1:0] standby_wait;
      logic               use_off_wait;  // toggle held back until off_wait passes
   } chan_cfg_type;

   typedef struct packed {
      level_type level;
      ir_type    ir;
      sock_type  sock;
      req_type   pending;
   } chan_res_type;

endpackage

FILE: hdl/appliance_power_request_sequencer_unit.sv
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   display_draw, amp_draw, new_*_request
// rsp_      out        rsp_valid/rsp_stall   levels, IR and socket commands, pending
// csr_      in         csr_we                csr_index, csr_wdata
//
// One request per clock while rsp_stall is low; a request passes through the input register, then the result register.
// The per-appliance decision is a single compare-and-count pass between the two registers.
// Synchronous active-high reset clears both stages, the appliance state and loads the
// default settings. rsp_stall holds the result; the input register keeps taking a new
// request while its occupant can move on, so req_stall rises only when both stages are full.
module appliance_power_request_sequencer_unit (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [apr_pkg::DRAW_W-1:0]        req_display_draw,
   input  logic [apr_pkg::DRAW_W-1:0]        req_amp_draw,
   input  logic [1:0]                        req_new_display_request,
   input  logic [1:0]                        req_new_amp_request,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_display_level,
   output logic [1:0]                        rsp_amp_level,
   output logic [1:0]                        rsp_display_ir_cmd,
   output logic [1:0]                        rsp_display_socket_cmd,
   output logic                              rsp_amp_ir_toggle,
   output logic [1:0]                        rsp_amp_socket_cmd,
   output logic [1:0]                        rsp_display_pending,
   output logic [1:0]                        rsp_amp_pending,
   // settings
   input  logic                              csr_we,
   input  logic [apr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [apr_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import apr_pkg::*;

   // settings registers
   logic [DRAW_W-1:0]  disp_on_level_ff;
   logic [DRAW_W-1:0]  amp_on_level_ff;
   logic [TICKS_W-1:0] disp_off_wait_ff;
   logic [TICKS_W-1:0] disp_standby_wait_ff;
   logic [TICKS_W-1:0] amp_standby_wait_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         disp_on_level_ff     <= RST_DISPLAY_ON_LEVEL;
         amp_on_level_ff      <= RST_AMP_ON_LEVEL;
         disp_off_wait_ff     <= RST_DISPLAY_OFF_WAIT;
         disp_standby_wait_ff <= RST_DISPLAY_STANDBY_WAIT;
         amp_standby_wait_ff  <= RST_AMP_STANDBY_WAIT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DISPLAY_ON_LEVEL:     disp_on_level_ff     <= csr_wdata;
            CSR_AMP_ON_LEVEL:         amp_on_level_ff      <= csr_wdata;
            CSR_DISPLAY_OFF_WAIT:     disp_off_wait_ff     <= csr_wdata[TICKS_W-1:0];
            CSR_DISPLAY_STANDBY_WAIT: disp_standby_wait_ff <= csr_wdata[TICKS_W-1:0];
            CSR_AMP_STANDBY_WAIT:     amp_standby_wait_ff  <= csr_wdata[TICKS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // input register
   logic               in_valid_ff, in_valid_in;
   logic [DRAW_W-1:0]  in_disp_draw_ff, in_amp_draw_ff;
   logic [1:0]         in_disp_req_ff, in_amp_req_ff;
   logic               req_take;
   logic               advance;

   // result register
   logic               out_valid_ff, out_valid_in;
   chan_res_type       disp_res, amp_res;
   chan_res_type       disp_res_ff, amp_res_ff;

   assign advance   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_stall) begin
         out_valid_in = out_valid_ff;
      end else begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_disp_draw_ff <= req_display_draw;
         in_amp_draw_ff  <= req_amp_draw;
         in_disp_req_ff  <= req_new_display_request;
         in_amp_req_ff   <= req_new_amp_request;
      end
      if (advance) begin
         disp_res_ff <= disp_res;
         amp_res_ff  <= amp_res;
      end
   end

   chan_cfg_type disp_cfg, amp_cfg;

   // display toggle waits for off_wait; amplifier toggles at once
   assign disp_cfg = '{on_level:     disp_on_level_ff,
                       off_wait:     disp_off_wait_ff,
                       standby_wait: disp_standby_wait_ff,
                       use_off_wait: 1'b1};
   assign amp_cfg  = '{on_level:     amp_on_level_ff,
                       off_wait:     '0,
                       standby_wait: amp_standby_wait_ff,
                       use_off_wait: 1'b0};

   apr_channel u_display (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .draw    (in_disp_draw_ff),
      .new_req (in_disp_req_ff),
      .cfg     (disp_cfg),
      .res     (disp_res)
   );

   apr_channel u_amp (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .draw    (in_amp_draw_ff),
      .new_req (in_amp_req_ff),
      .cfg     (amp_cfg),
      .res     (amp_res)
   );

   assign rsp_valid              = out_valid_ff;
   assign rsp_display_level      = disp_res_ff.level;
   assign rsp_amp_level          = amp_res_ff.level;
   assign rsp_display_ir_cmd     = disp_res_ff.ir;
   assign rsp_display_socket_cmd = disp_res_ff.sock;
   // amplifier has a single IR code: any command is the power toggle
   assign rsp_amp_ir_toggle      = (amp_res_ff.ir != IR_NONE);
   assign rsp_amp_socket_cmd     = amp_res_ff.sock;
   assign rsp_display_pending    = disp_res_ff.pending;
   assign rsp_amp_pending        = amp_res_ff.pending;

endmodule

FILE: hdl/apr_channel.sv
module apr_channel (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [apr_pkg::DRAW_W-1:0]  draw,
   input  logic [1:0]                  new_req,
   input  apr_pkg::chan_cfg_type       cfg,
   output apr_pkg::chan_res_type       res
);
   import apr_pkg::*;

   req_type              request_ff, request_in;
   req_type              last_req_ff;
   level_type            last_level_ff;
   logic [TICKS_W-1:0]   level_ticks_ff, level_ticks_in;
   logic [TICKS_W-1:0]   req_ticks_ff, req_ticks_in;
   req_type              req_cur;
   level_type            level;

   always_comb begin
      if (new_req == REQ_ON || new_req == REQ_OFF) begin
         req_cur = req_type'(new_req);
      end else begin
         req_cur = request_ff;
      end

      if (draw > cfg.on_level) begin
         level = LVL_ON;
      end else if (draw != '0) begin
         level = LVL_STANDBY;
      end else begin
         level = LVL_OFF;
      end

      // saturating run lengths
      if (level != last_level_ff) begin
         level_ticks_in = '0;
      end else if (level_ticks_ff == TICKS_MAX) begin
         level_ticks_in = TICKS_MAX;
      end else begin
         level_ticks_in = level_ticks_ff + 1'b1;
      end

      if (req_cur != last_req_ff) begin
         req_ticks_in = '0;
      end else if (req_ticks_ff == TICKS_MAX) begin
         req_ticks_in = TICKS_MAX;
      end else begin
         req_ticks_in = req_ticks_ff + 1'b1;
      end
   end

   always_comb begin
      request_in = req_cur;
      res.ir     = IR_NONE;
      res.sock   = SOCK_NONE;
      case (req_cur)
         REQ_ON: begin
            if (level == LVL_ON) begin
               request_in = REQ_NONE;
            end else if (level == LVL_STANDBY) begin
               res.ir = IR_WAKE;
            end else begin
               res.sock = SOCK_ON;
            end
         end
         REQ_OFF: begin
            if (level != LVL_ON) begin
               request_in = REQ_NONE;
            end else if (!cfg.use_off_wait || req_ticks_in > cfg.off_wait) begin
               res.ir = IR_TOGGLE;
            end
         end
         default: begin
         end
      endcase
      // standby timeout overrides any socket-on
      if (level == LVL_STANDBY && level_ticks_in > cfg.standby_wait) begin
         res.sock = SOCK_OFF;
      end
      res.level   = level;
      res.pending = request_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         request_ff     <= REQ_NONE;
         last_req_ff    <= REQ_UNSET;
         last_level_ff  <= LVL_NONE;
         level_ticks_ff <= '0;
         req_ticks_ff   <= '0;
      end else if (advance) begin
         request_ff     <= request_in;
         last_req_ff    <= request_in;
         last_level_ff  <= level;
         level_ticks_ff <= level_ticks_in;
         req_ticks_ff   <= req_ticks_in;
      end
   end

   a_sock_on_needs_on_req: assert property (@(posedge clock) disable iff (reset)
      res.sock == SOCK_ON |-> res.pending == REQ_ON)
      else $error("socket on without pending on request");

   a_toggle_only_when_on: assert property (@(posedge clock) disable iff (reset)
      res.ir == IR_TOGGLE |-> res.level == LVL_ON && res.pending == REQ_OFF)
      else $error("power toggle while not on or no off request");

   a_level_change_clears: assert property (@(posedge clock) disable iff (reset)
      advance && level != last_level_ff |=> level_ticks_ff == '0)
      else $error("level counter not cleared on change");

   a_pending_defined: assert property (@(posedge clock) disable iff (reset)
      res.pending != REQ_UNSET)
      else $error("pending request holds the unset code");

endmodule

FILE: sim/appliance_power_request_sequencer_unit_test.sv
module appliance_power_request_sequencer_unit_test;
   import apr_pkg::*;

   // Longest legitimate spell with no request or result moving: the long receiver
   // hold-off plus an idle burst. QUIET_LIMIT lies far above this; reaching it means a hang.
   localparam int QUIET_LIMIT     = 1000;
   localparam int PHASE_REQUESTS  = 330;
   localparam int PHASE_COUNT     = 6;
   localparam int HOLD_OFF_CYCLES = 80;

   // what one tick should produce on the rsp_ channel
   typedef struct packed {
      level_type d_lvl;
      level_type a_lvl;
      ir_type    d_ir;
      sock_type  d_sock;
      logic      a_ir;
      sock_type  a_sock;
      req_type   d_pend;
      req_type   a_pend;
   } tick_outcome_type;

   // one request as offered on the req_ channel, plus an optional hand-typed outcome
   typedef struct packed {
      logic [DRAW_W-1:0] d_draw;
      logic [DRAW_W-1:0] a_draw;
      req_type           d_new;
      req_type           a_new;
      logic              typed;
      tick_outcome_type  want;
   } tick_row_type;

   // per-appliance memory of the sequencer
   typedef struct packed {
      req_type            want;
      req_type            last_want;
      level_type          last_lvl;
      logic [TICKS_W-1:0] lvl_ticks;
      logic [TICKS_W-1:0] want_ticks;
   } appliance_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [DRAW_W-1:0]     req_display_draw;
   logic [DRAW_W-1:0]     req_amp_draw;
   logic [1:0]            req_new_display_request;
   logic [1:0]            req_new_amp_request;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [1:0]            rsp_display_level;
   logic [1:0]            rsp_amp_level;
   logic [1:0]            rsp_display_ir_cmd;
   logic [1:0]            rsp_display_socket_cmd;
   logic                  rsp_amp_ir_toggle;
   logic [1:0]            rsp_amp_socket_cmd;
   logic [1:0]            rsp_display_pending;
   logic [1:0]            rsp_amp_pending;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // predictor's copy of the settings
   logic [DRAW_W-1:0]  disp_on_level  = RST_DISPLAY_ON_LEVEL;
   logic [DRAW_W-1:0]  amp_on_level   = RST_AMP_ON_LEVEL;
   logic [TICKS_W-1:0] disp_off_wait  = RST_DISPLAY_OFF_WAIT;
   logic [TICKS_W-1:0] disp_sb_wait   = RST_DISPLAY_STANDBY_WAIT;
   logic [TICKS_W-1:0] amp_sb_wait    = RST_AMP_STANDBY_WAIT;

   // predictor's copy of the appliance state, as after reset
   appliance_type disp_state = '{REQ_NONE, REQ_UNSET, LVL_NONE, '0, '0};
   appliance_type amp_state  = '{REQ_NONE, REQ_UNSET, LVL_NONE, '0, '0};

   tick_outcome_type awaited_outcomes[$];
   tick_row_type     plan[$];
   tick_outcome_type arrived;

   int  mismatches       = 0;
   int  results_checked  = 0;
   int  requests_sent    = 0;
   int  quiet_cycles     = 0;
   int  toggles_seen     = 0;
   int  wakes_seen       = 0;
   int  socket_offs_seen = 0;
   bit  saw_saturation   = 0;
   bit  calm             = 0;   // final stretch: no idling on either side
   bit  want_hold        = 0;   // asks the receiver for one long hold-off

   appliance_power_request_sequencer_unit dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_display_draw        (req_display_draw),
      .req_amp_draw            (req_amp_draw),
      .req_new_display_request (req_new_display_request),
      .req_new_amp_request     (req_new_amp_request),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_display_level       (rsp_display_level),
      .rsp_amp_level           (rsp_amp_level),
      .rsp_display_ir_cmd      (rsp_display_ir_cmd),
      .rsp_display_socket_cmd  (rsp_display_socket_cmd),
      .rsp_amp_ir_toggle       (rsp_amp_ir_toggle),
      .rsp_amp_socket_cmd      (rsp_amp_socket_cmd),
      .rsp_display_pending     (rsp_display_pending),
      .rsp_amp_pending         (rsp_amp_pending),
      .csr_we                  (csr_we),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   // One appliance for one tick. The display wakes from standby with its own IR
   // command and holds its power toggle back until the off wait has passed; the
   // amplifier uses its toggle for both and never waits.
   task automatic step_appliance(input logic [DRAW_W-1:0] draw, input req_type fresh,
                                 input logic [DRAW_W-1:0] on_level,
                                 input logic [TICKS_W-1:0] standby_wait,
                                 input logic [TICKS_W-1:0] off_wait,
                                 input bit is_display, inout appliance_type st,
                                 output chan_res_type res);
      level_type lvl;
      if (draw > on_level) lvl = LVL_ON;
      else if (draw != '0) lvl = LVL_STANDBY;
      else lvl = LVL_OFF;

      // code three (and zero) leave the pending request alone
      if (fresh == REQ_ON || fresh == REQ_OFF) st.want = fresh;

      // saturating "unchanged for" counters
      if (lvl != st.last_lvl) st.lvl_ticks = '0;
      else if (st.lvl_ticks != TICKS_MAX) st.lvl_ticks = st.lvl_ticks + 1'b1;
      if (st.want != st.last_want) st.want_ticks = '0;
      else if (st.want_ticks != TICKS_MAX) st.want_ticks = st.want_ticks + 1'b1;
      if (st.lvl_ticks == TICKS_MAX || st.want_ticks == TICKS_MAX) saw_saturation = 1'b1;

      res.level = lvl;
      res.ir    = IR_NONE;
      res.sock  = SOCK_NONE;
      case (st.want)
         REQ_ON: begin
            if (lvl == LVL_ON) st.want = REQ_NONE;
            else if (lvl == LVL_STANDBY) res.ir = is_display ? IR_WAKE : IR_TOGGLE;
            else res.sock = SOCK_ON;
         end
         REQ_OFF: begin
            if (lvl != LVL_ON) st.want = REQ_NONE;
            else if (!is_display || st.want_ticks > off_wait) res.ir = IR_TOGGLE;
         end
         default: ;
      endcase

      // parked in standby too long: cut the socket
      if (lvl == LVL_STANDBY && st.lvl_ticks > standby_wait) res.sock = SOCK_OFF;

      st.last_lvl  = lvl;
      st.last_want = st.want;
      res.pending  = st.want;
   endtask

   task automatic predict_outcome(input tick_row_type r, output tick_outcome_type o);
      chan_res_type d_res;
      chan_res_type a_res;
      step_appliance(r.d_draw, r.d_new, disp_on_level, disp_sb_wait, disp_off_wait,
                     1'b1, disp_state, d_res);
      step_appliance(r.a_draw, r.a_new, amp_on_level, amp_sb_wait, 8'd0,
                     1'b0, amp_state, a_res);
      o.d_lvl  = d_res.level;
      o.a_lvl  = a_res.level;
      o.d_ir   = d_res.ir;
      o.d_sock = d_res.sock;
      o.a_ir   = (a_res.ir != IR_NONE);
      o.a_sock = a_res.sock;
      o.d_pend = d_res.pending;
      o.a_pend = a_res.pending;
   endtask

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   function automatic tick_outcome_type spell(level_type dl, level_type al, ir_type di,
                                              sock_type ds, logic ai, sock_type as_,
                                              req_type dp, req_type ap);
      tick_outcome_type o;
      o = '{dl, al, di, ds, ai, as_, dp, ap};
      return o;
   endfunction

   // kind: 0 off, 1 standby, 2 on, 3 anything, 4 near the edges
   function automatic logic [DRAW_W-1:0] pick_draw(input int kind,
                                                   input logic [DRAW_W-1:0] on_level);
      case (kind)
         0: return '0;
         1: return (on_level == '0) ? '0 : DRAW_W'($urandom_range(1, int'(on_level)));
         2: return (on_level == '1) ? '1 :
                   DRAW_W'($urandom_range(int'(on_level) + 1, 65535));
         3: return DRAW_W'($urandom);
         default: begin
            case ($urandom_range(0, 3))
               0: return on_level;
               1: return on_level + 1'b1;
               2: return DRAW_W'(1);
               default: return '1;
            endcase
         end
      endcase
   endfunction

   // mostly "keep"; now and then a fresh on, off or the ignored code three
   function automatic req_type fresh_request();
      if ($urandom_range(0, 15) != 0) return REQ_NONE;
      return req_type'($urandom_range(1, 3));
   endfunction

   task automatic sender_gap();
      if (!calm && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   // Offer one request, hold it until taken, then log what it should produce.
   task automatic offer_request(input tick_row_type r);
      tick_outcome_type predicted;
      req_valid               <= 1'b1;
      req_display_draw        <= r.d_draw;
      req_amp_draw            <= r.a_draw;
      req_new_display_request <= r.d_new;
      req_new_amp_request     <= r.a_new;
      forever begin
         @(posedge clock);
         if (req_stall === 1'b0) break;
      end
      predict_outcome(r, predicted);
      awaited_outcomes.push_back(r.typed ? r.want : predicted);
      requests_sent++;
      @(negedge clock);
   endtask

   // stop offering and let every outstanding result come home
   task automatic drain();
      req_valid <= 1'b0;
      while (awaited_outcomes.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_setting(input logic [CSR_IDX_W-1:0] idx,
                                input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   // 8-bit registers take the low byte; the upper byte may carry junk
   task automatic load_settings(input logic [15:0] d_on, input logic [15:0] a_on,
                                input logic [15:0] d_off, input logic [15:0] d_sb,
                                input logic [15:0] a_sb);
      write_setting(CSR_DISPLAY_ON_LEVEL, d_on);
      write_setting(CSR_AMP_ON_LEVEL, a_on);
      write_setting(CSR_DISPLAY_OFF_WAIT, d_off);
      write_setting(CSR_DISPLAY_STANDBY_WAIT, d_sb);
      write_setting(CSR_AMP_STANDBY_WAIT, a_sb);
      csr_we <= 1'b0;
      disp_on_level = d_on;
      amp_on_level  = a_on;
      disp_off_wait = d_off[TICKS_W-1:0];
      disp_sb_wait  = d_sb[TICKS_W-1:0];
      amp_sb_wait   = a_sb[TICKS_W-1:0];
   endtask

   task automatic compare_field(input string what, input logic [1:0] want,
                                input logic [1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Sender: directed table, then six settings phases of shaped random ticks
   // ---------------------------------------------------------------------------
   initial begin
      tick_row_type r;
      int           phase;
      int           k;
      int           d_kind;
      int           a_kind;
      int           d_left;
      int           a_left;

      reset                   = 1'b1;
      req_valid               = 1'b0;
      req_display_draw        = '0;
      req_amp_draw            = '0;
      req_new_display_request = REQ_NONE;
      req_new_amp_request     = REQ_NONE;
      csr_we                  = 1'b0;
      csr_index               = CSR_DISPLAY_ON_LEVEL;
      csr_wdata               = '0;
      d_left                  = 0;
      a_left                  = 0;
      d_kind                  = 0;
      a_kind                  = 0;

      // Directed table, all at reset settings (on levels 50/100, waits 30/30/5).
      // Hand-typed rows: first tick both off; full draw with on requests (cleared at
      // once); zero draw with on requests (sockets on); standby with on pending
      // (display wake, amp toggle); code three keeps the request; draw equal to the
      // on level is standby and clears an off request; on with off pending (amp
      // toggles, display still inside its off wait).
      plan.push_back('{16'd0, 16'd0, REQ_NONE, REQ_NONE, 1'b1,
         spell(LVL_OFF, LVL_OFF, IR_NONE, SOCK_NONE, 1'b0, SOCK_NONE, REQ_NONE, REQ_NONE)});
      plan.push_back('{16'hFFFF, 16'hFFFF, REQ_ON, REQ_ON, 1'b1,
         spell(LVL_ON, LVL_ON, IR_NONE, SOCK_NONE, 1'b0, SOCK_NONE, REQ_NONE, REQ_NONE)});
      plan.push_back('{16'd0, 16'd0, REQ_ON, REQ_ON, 1'b1,
         spell(LVL_OFF, LVL_OFF, IR_NONE, SOCK_ON, 1'b0, SOCK_ON, REQ_ON, REQ_ON)});
      plan.push_back('{16'd1, 16'd1, REQ_NONE, REQ_NONE, 1'b1,
         spell(LVL_STANDBY, LVL_STANDBY, IR_WAKE, SOCK_NONE, 1'b1, SOCK_NONE, REQ_ON,
               REQ_ON)});
      plan.push_back('{16'd51, 16'd101, REQ_UNSET, REQ_UNSET, 1'b1,
         spell(LVL_ON, LVL_ON, IR_NONE, SOCK_NONE, 1'b0, SOCK_NONE, REQ_NONE, REQ_NONE)});
      plan.push_back('{16'd50, 16'd100, REQ_OFF, REQ_OFF, 1'b1,
         spell(LVL_STANDBY, LVL_STANDBY, IR_NONE, SOCK_NONE, 1'b0, SOCK_NONE, REQ_NONE,
               REQ_NONE)});
      plan.push_back('{16'hFFFF, 16'hFFFF, REQ_OFF, REQ_OFF, 1'b1,
         spell(LVL_ON, LVL_ON, IR_NONE, SOCK_NONE, 1'b1, SOCK_NONE, REQ_OFF, REQ_OFF)});
      // amp parked in standby past its wait of five: socket off on the seventh tick;
      // display stays on with its off request waiting
      for (k = 0; k < 7; k++)
         plan.push_back('{16'd100, 16'd10, REQ_NONE, REQ_NONE, 1'b0, '0});
      plan.push_back('{16'd0, 16'd0, REQ_ON, REQ_OFF, 1'b0, '0});
      plan.push_back('{16'hFFFF, 16'hFFFF, REQ_NONE, REQ_ON, 1'b0, '0});
      plan.push_back('{16'd3, 16'd0, REQ_UNSET, REQ_NONE, 1'b0, '0});

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) begin
         sender_gap();
         offer_request(plan[i]);
      end

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase != 0) begin
            drain();
            case (phase)
               1: load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
               2: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF, 16'hFFFF);
               3: load_settings(16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
                                16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)),
                                16'($urandom_range(0, 8)));
               4: load_settings(16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom), 16'($urandom));
               default: load_settings(16'd200, 16'd300, 16'd2, 16'd12, 16'd1);
            endcase
         end
         if (phase == PHASE_COUNT - 1) calm = 1'b1;
         if (phase == 3) want_hold = 1'b1;   // receiver goes deaf, input backs up

         for (k = 0; k < PHASE_REQUESTS; k++) begin
            // sender waits for the pipeline to empty halfway through one phase
            if (phase == 4 && k == PHASE_REQUESTS / 2) drain();
            // draws hold a class for a run of ticks so the counters get somewhere;
            // the odd long run drives them into saturation
            if (d_left == 0) begin
               if ($urandom_range(0, 19) == 0) begin
                  d_kind = $urandom_range(0, 2);
                  d_left = 270;
               end else begin
                  d_kind = $urandom_range(0, 4);
                  d_left = $urandom_range(1, 40);
               end
            end
            if (a_left == 0) begin
               if ($urandom_range(0, 19) == 0) begin
                  a_kind = $urandom_range(0, 2);
                  a_left = 270;
               end else begin
                  a_kind = $urandom_range(0, 4);
                  a_left = $urandom_range(1, 40);
               end
            end
            d_left--;
            a_left--;
            r.d_draw = pick_draw(d_kind, disp_on_level);
            r.a_draw = pick_draw(a_kind, amp_on_level);
            r.d_new  = fresh_request();
            r.a_new  = fresh_request();
            r.typed  = 1'b0;
            r.want   = '0;
            sender_gap();
            offer_request(r);
         end
      end

      drain();
      $display("Checked %0d results against %0d requests over %0d settings phases, %0d mismatches.",
               results_checked, requests_sent, PHASE_COUNT, mismatches);
      $display("Seen %0d display toggles, %0d wake commands, %0d socket cuts; saturation %s.",
               toggles_seen, wakes_seen, socket_offs_seen, saw_saturation ? "reached" : "missed");
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Receiver: random stall bursts, one long hold-off on request, none when calm
   // ---------------------------------------------------------------------------
   initial begin
      int burst;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (want_hold) begin
            want_hold = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 12);
            rsp_stall <= 1'b1;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Result checker: every accepted result against the oldest expectation
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (awaited_outcomes.size() == 0) begin
            mismatches++;
            $display("%0t: result arrived with nothing expected", $time);
         end else begin
            arrived = awaited_outcomes.pop_front();
            compare_field("display_level", arrived.d_lvl, rsp_display_level);
            compare_field("amp_level", arrived.a_lvl, rsp_amp_level);
            compare_field("display_ir_cmd", arrived.d_ir, rsp_display_ir_cmd);
            compare_field("display_socket_cmd", arrived.d_sock, rsp_display_socket_cmd);
            compare_field("amp_ir_toggle", {1'b0, arrived.a_ir}, {1'b0, rsp_amp_ir_toggle});
            compare_field("amp_socket_cmd", arrived.a_sock, rsp_amp_socket_cmd);
            compare_field("display_pending", arrived.d_pend, rsp_display_pending);
            compare_field("amp_pending", arrived.a_pend, rsp_amp_pending);
            results_checked++;
            if (arrived.d_ir == IR_TOGGLE) toggles_seen++;
            if (arrived.d_ir == IR_WAKE) wakes_seen++;
            if (arrived.d_sock == SOCK_OFF || arrived.a_sock == SOCK_OFF) socket_offs_seen++;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Watchdog: too long with neither channel moving means the block has hung
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: timeout, %0d results still outstanding", $time,
                     awaited_outcomes.size());
            $display("Regression FAIL");
            $finish;
         end
      end
   end

endmodule

FILE: sim.f
hdl/apr_pkg.sv
hdl/apr_channel.sv
hdl/appliance_power_request_sequencer_unit.sv
sim/appliance_power_request_sequencer_unit_test.sv
